// ===== rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the stereo feedback delay: beat payloads,
// configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package sfd_pkg;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] RegDelay    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFeedback = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLowpass  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegClipEn   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPreGain  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPostGain = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMix      = 3'd6;

  localparam logic [16:0] DelayReset    = 17'd19200;
  localparam logic [15:0] FeedbackReset = 16'd26214;
  localparam logic [15:0] LowpassReset  = 16'd21286;
  localparam logic        ClipEnReset   = 1'b1;
  localparam logic [16:0] PreGainReset  = 17'd31130;
  localparam logic [15:0] PostGainReset = 16'd40960;
  localparam logic [16:0] MixReset      = 17'd32768;
  localparam logic [16:0] MixOne        = 17'd65536;

  // Stored samples are Q2.15, the filter state Q2.21.
  localparam int unsigned StoreW = 18;
  localparam int unsigned LpW    = 24;

endpackage

// ===== rtl/sfd_delay_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_delay_mem
// Simple dual-port delay store: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sfd_delay_mem #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned WIDTH = 36
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/stereo_feedback_delay_lp_saturation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_lp_saturation_top
// Stereo feedback delay with a one-pole lowpass and a tanh soft clip in the
// feedback path, run on one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_data_i  (left, right)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (left, right)
//  cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// An input beat runs RED_STEPS reduction steps (1 at the default depth) and
// more states with the soft clip on than with it off; the single multiplier,
// used up to seven times per channel, sets the length of a beat.
// The delay is first reduced modulo DELAY_DEPTH, one shifted subtract a cycle.
// Reset needs no clearing pass: a fill flag and the write index mark which
// store entries were ever written, and the rest read as zero.
// The output register frees the input side: a new beat is taken while the
// last result still waits out a stall.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_lp_saturation_top #(
  parameter int unsigned DELAY_DEPTH  = 131072,
  parameter int unsigned TANH_ENTRIES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sfd_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sfd_pkg::out_t                       out_data_o,
  input  logic                                cfg_we_i,
  input  logic [sfd_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [sfd_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned TW = $clog2(TANH_ENTRIES + 1);
  // Shifted subtracts needed to bring a 17-bit delay below the depth.
  localparam int unsigned RED_STEPS =
    (DELAY_DEPTH >= 131072) ? 1 : $clog2(131072 / DELAY_DEPTH) + 1;
  localparam int unsigned KW = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam int unsigned MW = 2 * sfd_pkg::StoreW;

  // tanh over [0,4] in Q1.15, built at elaboration by the addition recurrence.
  typedef logic [15:0] tanh_tab_t [TANH_ENTRIES+1];

  // Restoring shift-subtract quotient, evaluated at elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tanh_tab_t build_tanh();
    logic [63:0] x, x2, x3, x5, x7, h, t, q, num, den;
    tanh_tab_t   tab;
    x  = udiv64(64'd1 << 32, 64'(TANH_ENTRIES));
    x2 = (x * x) >> 30;
    x3 = (x2 * x) >> 30;
    x5 = (x3 * x2) >> 30;
    x7 = (x5 * x2) >> 30;
    h  = x - udiv64(x3, 64'd3) + udiv64(64'd2 * x5, 64'd15)
           - udiv64(64'd17 * x7, 64'd315);
    t  = 64'd0;
    for (int k = 0; k <= int'(TANH_ENTRIES); k++) begin
      q      = (t + 64'd16384) >> 15;
      tab[k] = (q > 64'd32767) ? 16'd32767 : q[15:0];
      num    = (t + h) << 30;
      den    = (64'd1 << 30) + ((t * h) >> 30);
      t      = udiv64(num + (den >> 1), den);
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sd8388607;
    if (v < -64'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [63:0] v);
    if (v > 64'sd131071) return 18'sd131071;
    if (v < -64'sd131072) return -18'sd131072;
    return v[17:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sd32767;
    if (v < -64'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  typedef enum logic [4:0] {
    StIdle, StRed, StAddr, StRdWait, StLpMul, StLpAdd, StClipMul, StClipIdx,
    StTabNext, StFracMul, StPostMul, StClipSign, StFbMul, StFbAdd,
    StBlendDry, StBlendWet, StBlendSum, StWrite, StDone
  } state_e;

  // Configuration registers.
  logic [16:0] delay_q, pre_gain_q, mix_q;
  logic [15:0] feedback_q, lowpass_q, post_gain_q;
  logic        clip_en_q;

  // Control.
  state_e          state_q;
  logic [KW-1:0]   k_q;
  logic [AW-1:0]   wr_idx_q;
  logic            full_q;
  logic            ch_q;
  logic            rd_valid_q;
  logic            out_valid_q;

  // Datapath.
  logic signed [sfd_pkg::LpW-1:0]    lp_l_q, lp_r_q, y_q;
  logic signed [15:0]                x_l_q, x_r_q, o_l_q, o_r_q;
  logic signed [sfd_pkg::StoreW-1:0] d_l_q, d_r_q, st_l_q, st_r_q;
  logic [16:0]                       dm_q;
  logic [29:0]                       pgn_q;
  logic signed [63:0]                prod_q, acc_q;
  logic [TW-1:0]                     tab_idx_q;
  logic [15:0]                       t0_q, t1_q, frac_q;
  sfd_pkg::out_t                     out_data_q;

  // Shared multiplier.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_d;

  // Per-channel views.
  logic signed [15:0]                xc;
  logic signed [sfd_pkg::StoreW-1:0] dc;
  logic signed [sfd_pkg::LpW-1:0]    lpc;
  logic [16:0]                       mix_eff;
  logic [AW:0]                       rd_sum;
  logic [AW-1:0]                     rd_addr;
  logic [15:0]                       tc;
  logic [22:0]                       mag;
  logic signed [63:0]                rnd_v;
  logic [MW-1:0]                     mem_rdata;
  logic                              mem_we, mem_re;
  logic                              ovf;
  logic [31:0]                       red_cmp;

  assign xc      = ch_q ? x_r_q : x_l_q;
  assign dc      = ch_q ? d_r_q : d_l_q;
  assign lpc     = ch_q ? lp_r_q : lp_l_q;
  assign mix_eff = (mix_q > sfd_pkg::MixOne) ? sfd_pkg::MixOne : mix_q;
  assign tc      = t0_q + prod_q[31:16];
  assign mag     = 23'((prod_q + 64'sd512) >>> 10);
  assign ovf     = prod_q[63:37] >= 27'(TANH_ENTRIES);
  assign red_cmp = 32'(DELAY_DEPTH) << k_q;

  // Read position: write index minus the reduced delay, wrapped once.
  always_comb begin
    rd_sum  = {1'b0, wr_idx_q} + (AW+1)'(DELAY_DEPTH) - (AW+1)'(dm_q);
    rd_addr = (rd_sum >= (AW+1)'(DELAY_DEPTH)) ? AW'(rd_sum - (AW+1)'(DELAY_DEPTH))
                                               : rd_sum[AW-1:0];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    case (state_q)
      StRdWait: begin
        mul_a = 32'(pre_gain_q);
        mul_b = 32'(TANH_ENTRIES);
      end
      StLpMul: begin
        mul_a = (32'(dc) <<< 6) - 32'(lpc);
        mul_b = 32'(lowpass_q);
      end
      StClipMul: begin
        mul_a = y_q[sfd_pkg::LpW-1] ? -32'(y_q) : 32'(y_q);
        mul_b = 32'(pgn_q);
      end
      StFracMul: begin
        mul_a = 32'(t1_q - t0_q);
        mul_b = 32'(frac_q);
      end
      StPostMul: begin
        mul_a = 32'(tc);
        mul_b = 32'(post_gain_q);
      end
      StFbMul: begin
        mul_a = 32'(y_q);
        mul_b = 32'(feedback_q);
      end
      StBlendDry: begin
        mul_a = 32'(xc);
        mul_b = 32'(sfd_pkg::MixOne - mix_eff);
      end
      StBlendWet: begin
        mul_a = 32'(dc);
        mul_b = 32'(mix_eff);
      end
      default: ;
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    case (state_q)
      StFbAdd:    rnd_v = (prod_q + 64'sd2097152) >>> 22;
      StBlendSum: rnd_v = (acc_q + prod_q + 64'sd32768) >>> 16;
      default:    rnd_v = (prod_q + 64'sd32768) >>> 16;
    endcase
  end

  assign mem_re = (state_q == StAddr);
  assign mem_we = (state_q == StWrite);

  sfd_delay_mem #(
    .DEPTH (DELAY_DEPTH),
    .WIDTH (MW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_idx_q),
    .wdata_i ({st_l_q, st_r_q}),
    .re_i    (mem_re),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= sfd_pkg::DelayReset;
      feedback_q  <= sfd_pkg::FeedbackReset;
      lowpass_q   <= sfd_pkg::LowpassReset;
      clip_en_q   <= sfd_pkg::ClipEnReset;
      pre_gain_q  <= sfd_pkg::PreGainReset;
      post_gain_q <= sfd_pkg::PostGainReset;
      mix_q       <= sfd_pkg::MixReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfd_pkg::RegDelay:    delay_q     <= cfg_data_i;
        sfd_pkg::RegFeedback: feedback_q  <= cfg_data_i[15:0];
        sfd_pkg::RegLowpass:  lowpass_q   <= cfg_data_i[15:0];
        sfd_pkg::RegClipEn:   clip_en_q   <= cfg_data_i[0];
        sfd_pkg::RegPreGain:  pre_gain_q  <= cfg_data_i;
        sfd_pkg::RegPostGain: post_gain_q <= cfg_data_i[15:0];
        sfd_pkg::RegMix:      mix_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: state, control and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      k_q         <= '0;
      wr_idx_q    <= '0;
      full_q      <= 1'b0;
      ch_q        <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lp_l_q      <= '0;
      lp_r_q      <= '0;
    end else begin
      // Drop the result once the downstream side takes it, unless a new one
      // is loaded in the same cycle.
      if (out_valid_q && !out_stall_i && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            x_l_q   <= in_data_i.left_in;
            x_r_q   <= in_data_i.right_in;
            dm_q    <= delay_q;
            k_q     <= KW'(RED_STEPS - 1);
            state_q <= StRed;
          end
        end
        StRed: begin
          if (32'(dm_q) >= red_cmp) begin
            dm_q <= 17'(32'(dm_q) - red_cmp);
          end
          if (k_q == '0) begin
            state_q <= StAddr;
          end else begin
            k_q <= k_q - KW'(1);
          end
        end
        StAddr: begin
          // Entries beyond the write index were never written before the wrap.
          rd_valid_q <= full_q || (rd_addr < wr_idx_q);
          state_q    <= StRdWait;
        end
        StRdWait: begin
          d_l_q   <= rd_valid_q ? mem_rdata[MW-1:sfd_pkg::StoreW] : '0;
          d_r_q   <= rd_valid_q ? mem_rdata[sfd_pkg::StoreW-1:0] : '0;
          prod_q  <= prod_d;
          ch_q    <= 1'b0;
          state_q <= StLpMul;
        end
        StLpMul: begin
          if (ch_q == 1'b0) begin
            pgn_q <= prod_q[29:0];
          end
          prod_q  <= prod_d;
          state_q <= StLpAdd;
        end
        StLpAdd: begin
          y_q <= sat24(64'(lpc) + rnd_v);
          if (ch_q) begin
            lp_r_q <= sat24(64'(lpc) + rnd_v);
          end else begin
            lp_l_q <= sat24(64'(lpc) + rnd_v);
          end
          state_q <= clip_en_q ? StClipMul : StFbMul;
        end
        StClipMul: begin
          prod_q  <= prod_d;
          state_q <= StClipIdx;
        end
        StClipIdx: begin
          // Hold the last entry above the table range.
          tab_idx_q <= ovf ? TW'(TANH_ENTRIES) : prod_q[37+TW-1:37];
          frac_q    <= ovf ? 16'd0 : prod_q[36:21];
          t0_q      <= TANH_TAB[ovf ? TW'(TANH_ENTRIES) : prod_q[37+TW-1:37]];
          state_q   <= StTabNext;
        end
        StTabNext: begin
          t1_q    <= TANH_TAB[(tab_idx_q == TW'(TANH_ENTRIES)) ? tab_idx_q
                                                              : tab_idx_q + TW'(1)];
          state_q <= StFracMul;
        end
        StFracMul: begin
          prod_q  <= prod_d;
          state_q <= StPostMul;
        end
        StPostMul: begin
          prod_q  <= prod_d;
          state_q <= StClipSign;
        end
        StClipSign: begin
          y_q     <= y_q[sfd_pkg::LpW-1] ? -24'(mag) : 24'(mag);
          state_q <= StFbMul;
        end
        StFbMul: begin
          prod_q  <= prod_d;
          state_q <= StFbAdd;
        end
        StFbAdd: begin
          if (ch_q) begin
            st_r_q <= sat18(64'(xc) + rnd_v);
          end else begin
            st_l_q <= sat18(64'(xc) + rnd_v);
          end
          state_q <= StBlendDry;
        end
        StBlendDry: begin
          prod_q  <= prod_d;
          state_q <= StBlendWet;
        end
        StBlendWet: begin
          acc_q   <= prod_q;
          prod_q  <= prod_d;
          state_q <= StBlendSum;
        end
        StBlendSum: begin
          if (ch_q) begin
            o_r_q   <= sat16(rnd_v);
            state_q <= StWrite;
          end else begin
            o_l_q   <= sat16(rnd_v);
            ch_q    <= 1'b1;
            state_q <= StLpMul;
          end
        end
        StWrite: begin
          // Advance the write index; mark the store full on the first wrap.
          if (wr_idx_q == AW'(DELAY_DEPTH - 1)) begin
            wr_idx_q <= '0;
            full_q   <= 1'b1;
          end else begin
            wr_idx_q <= wr_idx_q + AW'(1);
          end
          state_q <= StDone;
        end
        StDone: begin
          // Hold until the output register is free.
          if (!out_valid_q || !out_stall_i) begin
            out_data_q.left_out  <= o_l_q;
            out_data_q.right_out <= o_r_q;
            out_valid_q          <= 1'b1;
            state_q              <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
